// File: src/mtrg_pkg.sv
package mtrg_pkg;

  // Reply buffer geometry
  localparam int REPLY_DEPTH = 256;
  localparam int IDX_W       = $clog2(REPLY_DEPTH);
  localparam int CNT_W       = $clog2(REPLY_DEPTH + 1);

  // Command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Protocol constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  LEN_MIN  = 8'd2;
  localparam logic [7:0]  LEN_MAX  = 8'd253;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [7:0]  EXC_CODE = 8'h0B;
  localparam logic [7:0]  EXC_LEN  = 8'd3;
  localparam logic [8:0]  HDR_LEN  = 9'd6;
  localparam int          MIN_REPLY = 4;

  // Result port codes
  localparam logic [1:0] PORT_BUS    = 2'd0;
  localparam logic [1:0] PORT_TCP    = 2'd1;
  localparam logic [1:0] PORT_STATUS = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_EXC     = 2'd2;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_REQ = 2'd0,
    KIND_REP = 2'd1,
    KIND_EOR = 2'd2,
    KIND_DRN = 2'd3
  } kind_t;

  // Commands handed from the front to the back
  typedef enum logic [2:0] {
    CMD_BAD_LEN  = 3'd0,
    CMD_REQ_BYTE = 3'd1,
    CMD_REQ_LAST = 3'd2,
    CMD_EXC      = 3'd3,
    CMD_HDR      = 3'd4,
    CMD_DRAIN    = 3'd5
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] w16;   // tid, request CRC or payload length
    logic [7:0]  b0;    // data byte, unit id, tid high byte or drained byte
    logic [7:0]  b1;    // function code or tid low byte
    logic        last;  // final drained byte
  } cmd_t;

  // One byte of the Modbus CRC-16 (reflected)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/modbus_tcp_rtu_gateway_framer_top.sv
// Channel | Handshake             | Fields
// input   | in_valid / in_ready   | in_kind, in_data
// result  | out_valid / out_ready | out_port, out_byte, out_last, out_status
//
// The front takes one transaction per cycle unless stalled, updates framer state and the reply buffer,
// and registers any command it yields, which then enters a four-entry queue.
// The back expands each command into one to nine results, one per cycle unless out_ready stalls it;
// the first result passes through the command register, the queue entry and the output register.
// Reset is synchronous, active low; the reply buffer is not cleared.
// The front stalls only when the queue is full; the back only on out_ready.
module modbus_tcp_rtu_gateway_framer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_port,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_status
);
  import mtrg_pkg::*;

  logic cf_valid;
  logic cf_ready;
  cmd_t cf_cmd;
  logic cb_valid;
  logic cb_ready;
  cmd_t cb_cmd;

  mtrg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_data   (in_data),
    .cmd_valid (cf_valid),
    .cmd_ready (cf_ready),
    .cmd       (cf_cmd)
  );

  mtrg_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cf_valid),
    .push_ready (cf_ready),
    .push_cmd   (cf_cmd),
    .pop_valid  (cb_valid),
    .pop_ready  (cb_ready),
    .pop_cmd    (cb_cmd)
  );

  mtrg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cb_valid),
    .cmd_ready  (cb_ready),
    .cmd        (cb_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_port   (out_port),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

// File: src/mtrg_front.sv
module mtrg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output mtrg_pkg::cmd_t    cmd
);
  import mtrg_pkg::*;

  logic [8:0]       req_pos_r, req_pos_nxt;
  logic [15:0]      tid_r, tid_nxt;
  logic [7:0]       pdu_len_r, pdu_len_nxt;
  logic [7:0]       unit_r, unit_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [15:0]      req_crc_r, req_crc_nxt;
  logic [15:0]      rep_crc_r, rep_crc_nxt;
  logic [CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic [IDX_W-1:0] drn_idx_r, drn_idx_nxt;
  logic             drn_pend_r, drn_pend_nxt;

  logic [7:0]       mem [REPLY_DEPTH];
  logic [7:0]       mem_rd_r;

  logic             s1_v_r;
  cmd_t             s1_r;
  cmd_t             cmd_nxt;
  logic             emit;
  logic             wr_en;
  logic             rd_en;
  logic             acc;
  kind_t            kind;
  logic [15:0]      crc_n;
  logic [CNT_W-1:0] plen;
  logic [CNT_W-1:0] idx_inc;

  assign kind     = kind_t'(in_kind);
  assign in_ready = !s1_v_r || cmd_ready;
  assign acc      = in_valid && in_ready;
  assign crc_n    = crc_byte(req_crc_r, in_data);
  assign plen     = rep_cnt_r - CNT_W'(2);
  assign idx_inc  = CNT_W'(drn_idx_r) + CNT_W'(1);

  // Classify the transaction and work out the next framer state
  always_comb begin
    req_pos_nxt  = req_pos_r;
    tid_nxt      = tid_r;
    pdu_len_nxt  = pdu_len_r;
    unit_nxt     = unit_r;
    func_nxt     = func_r;
    req_crc_nxt  = req_crc_r;
    rep_crc_nxt  = rep_crc_r;
    rep_cnt_nxt  = rep_cnt_r;
    drn_idx_nxt  = drn_idx_r;
    drn_pend_nxt = drn_pend_r;
    cmd_nxt      = '0;
    emit         = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    unique case (kind)
      KIND_REQ: begin
        if (req_pos_r < 9'd6) begin
          req_pos_nxt = req_pos_r + 9'd1;
          priority if (req_pos_r == 9'd0) begin
            tid_nxt = {in_data, 8'h00};
          end else if (req_pos_r == 9'd1) begin
            tid_nxt = {tid_r[15:8], in_data};
          end else if (req_pos_r == 9'd4) begin
            pdu_len_nxt = in_data;
          end else if (req_pos_r == 9'd5) begin
            if (pdu_len_r != 8'd0 || in_data < LEN_MIN || in_data > LEN_MAX) begin
              req_pos_nxt = 9'd0;
              emit        = 1'b1;
              cmd_nxt.op  = CMD_BAD_LEN;
            end else begin
              pdu_len_nxt = in_data;
              req_crc_nxt = CRC_INIT;
            end
          end else begin
            req_pos_nxt = req_pos_r + 9'd1;
          end
        end else begin
          if (req_pos_r == 9'd6) unit_nxt = in_data;
          if (req_pos_r == 9'd7) func_nxt = in_data;
          req_crc_nxt = crc_n;
          emit        = 1'b1;
          cmd_nxt.b0  = in_data;
          cmd_nxt.w16 = crc_n;
          if (req_pos_r - 9'd5 >= {1'b0, pdu_len_r}) begin
            // Close the request frame and flush the reply side
            cmd_nxt.op   = CMD_REQ_LAST;
            req_pos_nxt  = 9'd0;
            rep_cnt_nxt  = '0;
            rep_crc_nxt  = CRC_INIT;
            drn_pend_nxt = 1'b0;
            drn_idx_nxt  = '0;
          end else begin
            cmd_nxt.op  = CMD_REQ_BYTE;
            req_pos_nxt = req_pos_r + 9'd1;
          end
        end
      end
      KIND_REP: begin
        if (!drn_pend_r && rep_cnt_r < CNT_W'(REPLY_DEPTH)) begin
          wr_en       = 1'b1;
          rep_cnt_nxt = rep_cnt_r + CNT_W'(1);
          rep_crc_nxt = crc_byte(rep_crc_r, in_data);
        end
      end
      KIND_EOR: begin
        if (!drn_pend_r) begin
          emit        = 1'b1;
          cmd_nxt.w16 = tid_r;
          if (rep_cnt_r < CNT_W'(MIN_REPLY) || rep_crc_r != 16'h0000) begin
            cmd_nxt.op  = CMD_EXC;
            cmd_nxt.b0  = unit_r;
            cmd_nxt.b1  = func_r;
            rep_cnt_nxt = '0;
            rep_crc_nxt = CRC_INIT;
          end else begin
            cmd_nxt.op   = CMD_HDR;
            cmd_nxt.b0   = tid_r[15:8];
            cmd_nxt.b1   = tid_r[7:0];
            cmd_nxt.w16  = 16'(plen);
            drn_pend_nxt = 1'b1;
            drn_idx_nxt  = '0;
          end
        end
      end
      KIND_DRN: begin
        if (drn_pend_r) begin
          emit         = 1'b1;
          rd_en        = 1'b1;
          cmd_nxt.op   = CMD_DRAIN;
          cmd_nxt.last = (idx_inc >= plen);
          if (idx_inc >= plen) begin
            drn_pend_nxt = 1'b0;
            drn_idx_nxt  = '0;
            rep_cnt_nxt  = '0;
            rep_crc_nxt  = CRC_INIT;
          end else begin
            drn_idx_nxt = drn_idx_r + IDX_W'(1);
          end
        end
      end
    endcase
  end

  // Advance framer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_pos_r  <= '0;
      tid_r      <= '0;
      pdu_len_r  <= '0;
      unit_r     <= '0;
      func_r     <= '0;
      req_crc_r  <= CRC_INIT;
      rep_crc_r  <= CRC_INIT;
      rep_cnt_r  <= '0;
      drn_idx_r  <= '0;
      drn_pend_r <= 1'b0;
    end else if (acc) begin
      req_pos_r  <= req_pos_nxt;
      tid_r      <= tid_nxt;
      pdu_len_r  <= pdu_len_nxt;
      unit_r     <= unit_nxt;
      func_r     <= func_nxt;
      req_crc_r  <= req_crc_nxt;
      rep_crc_r  <= rep_crc_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      drn_idx_r  <= drn_idx_nxt;
      drn_pend_r <= drn_pend_nxt;
    end
  end

  // Buffer reply bytes; read a drained byte into a held register
  always_ff @(posedge clk) begin
    if (acc && wr_en) mem[rep_cnt_r[IDX_W-1:0]] <= in_data;
    if (acc && rd_en) mem_rd_r <= mem[drn_idx_r];
  end

  // Hold the classified command until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s1_r <= cmd_nxt;
  end

  assign cmd_valid = s1_v_r;

  always_comb begin
    cmd = s1_r;
    if (s1_r.op == CMD_DRAIN) cmd.b0 = mem_rd_r;
  end

  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    drn_pend_r |-> rep_cnt_r >= CNT_W'(MIN_REPLY))
    else $error("drain pending with a short reply");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    drn_pend_r |-> CNT_W'(drn_idx_r) < plen)
    else $error("drain index past payload");

endmodule

// File: src/mtrg_cmd_fifo.sv
module mtrg_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mtrg_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mtrg_pkg::cmd_t pop_cmd
);
  import mtrg_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_cmd;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("command queue overfilled");

endmodule

// File: src/mtrg_back.sv
module mtrg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mtrg_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_port,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic [1:0]     out_status
);
  import mtrg_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       out_v_r;
  logic [1:0] port_r, port_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic       final_step;
  logic       load;

  assign load      = cmd_valid && (!out_v_r || out_ready);
  assign cmd_ready = load && final_step;
  assign step_nxt  = final_step ? 4'd0 : step_r + 4'd1;

  // Expand the head command into one result per step
  always_comb begin
    port_nxt   = PORT_TCP;
    byte_nxt   = 8'h00;
    last_nxt   = 1'b0;
    stat_nxt   = ST_OK;
    final_step = 1'b1;
    unique case (cmd.op)
      CMD_BAD_LEN: begin
        port_nxt = PORT_STATUS;
        stat_nxt = ST_BAD_LEN;
      end
      CMD_REQ_BYTE: begin
        port_nxt = PORT_BUS;
        byte_nxt = cmd.b0;
      end
      CMD_REQ_LAST: begin
        port_nxt   = PORT_BUS;
        final_step = step_r == 4'd2;
        last_nxt   = step_r == 4'd2;
        unique case (step_r)
          4'd0:    byte_nxt = cmd.b0;
          4'd1:    byte_nxt = cmd.w16[7:0];
          default: byte_nxt = cmd.w16[15:8];
        endcase
      end
      CMD_EXC: begin
        stat_nxt   = ST_EXC;
        final_step = step_r == 4'd8;
        last_nxt   = step_r == 4'd8;
        unique case (step_r)
          4'd0:    byte_nxt = cmd.w16[15:8];
          4'd1:    byte_nxt = cmd.w16[7:0];
          4'd5:    byte_nxt = EXC_LEN;
          4'd6:    byte_nxt = cmd.b0;
          4'd7:    byte_nxt = cmd.b1 | EXC_FLAG;
          4'd8:    byte_nxt = EXC_CODE;
          default: byte_nxt = 8'h00;
        endcase
      end
      CMD_HDR: begin
        final_step = step_r == 4'd5;
        unique case (step_r)
          4'd0:    byte_nxt = cmd.b0;
          4'd1:    byte_nxt = cmd.b1;
          4'd4:    byte_nxt = cmd.w16[15:8];
          4'd5:    byte_nxt = cmd.w16[7:0];
          default: byte_nxt = 8'h00;
        endcase
      end
      CMD_DRAIN: begin
        byte_nxt = cmd.b0;
        last_nxt = cmd.last;
      end
      default: begin
        port_nxt = PORT_STATUS;
      end
    endcase
  end

  // Step through results and hold the output register while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 4'd0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        step_r  <= step_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      port_r <= port_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_port   = port_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_status = stat_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 4'd8)
    else $error("result step out of range");

  a_mid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 4'd0 |-> cmd_valid)
    else $error("command left the queue mid expansion");

endmodule

// File: verif/modbus_tcp_rtu_gateway_framer_top_tb.sv
module modbus_tcp_rtu_gateway_framer_top_tb;
  import mtrg_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 20;

  // One result transaction as seen on the out_ channel
  typedef struct packed {
    logic [1:0] port;
    logic [7:0] octet;
    logic       last;
    logic [1:0] status;
  } gw_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind = 2'd0;
  logic [7:0] in_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_port;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] out_status;

  // Framer state as the checker tracks it
  logic [8:0]  gw_req_pos = '0;
  logic [15:0] gw_tid = '0;
  logic [7:0]  gw_pdu_len = '0;
  logic [7:0]  gw_unit = '0;
  logic [7:0]  gw_func = '0;
  logic [15:0] gw_req_crc = CRC_INIT;
  logic [15:0] gw_reply_crc = CRC_INIT;
  logic [7:0]  gw_reply_buf [REPLY_DEPTH];
  logic [8:0]  gw_reply_count = '0;
  logic [8:0]  gw_drain_idx = '0;
  bit          gw_drain_pending = 1'b0;

  gw_result_t expected_bytes [$];
  int         error_count = 0;
  int         items_applied = 0;
  int         cycle_count = 0;
  int         sink_hold_cycles = 0;
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;

  modbus_tcp_rtu_gateway_framer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_port   (out_port),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bitwise reflected CRC-16, data bit folded into the feedback
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void expect_result(input logic [1:0] port, input logic [7:0] octet,
                                        input logic last, input logic [1:0] status);
    expected_bytes.push_back('{port, octet, last, status});
  endfunction

  // Advance the framer state by one input transaction and queue its results
  function automatic void predict_framer_output(input kind_t kind, input logic [7:0] d,
                                                output bit effective);
    logic [15:0] plen;
    logic [8:0]  idx;
    logic        last;
    bit          bad_len;
    effective = 1'b1;
    bad_len   = 1'b0;
    plen      = 16'(gw_reply_count) - 16'd2;
    case (kind)
      KIND_REQ: begin
        if (gw_req_pos < HDR_LEN) begin
          // walk the MBAP header; only tid and length are kept
          case (gw_req_pos)
            9'd0: gw_tid = {d, 8'h00};
            9'd1: gw_tid[7:0] = d;
            9'd4: gw_pdu_len = d;
            9'd5: begin
              if (gw_pdu_len != 8'd0 || d < LEN_MIN || d > LEN_MAX) begin
                expect_result(PORT_STATUS, 8'h00, 1'b0, ST_BAD_LEN);
                gw_req_pos = '0;
                bad_len    = 1'b1;
              end else begin
                gw_pdu_len = d;
                gw_req_crc = CRC_INIT;
              end
            end
            default: ;
          endcase
          if (!bad_len) gw_req_pos = gw_req_pos + 9'd1;
        end else begin
          // forward unit and PDU bytes, then the CRC low byte first
          if (gw_req_pos == HDR_LEN) gw_unit = d;
          else if (gw_req_pos == HDR_LEN + 9'd1) gw_func = d;
          gw_req_crc = crc16_step(gw_req_crc, d);
          expect_result(PORT_BUS, d, 1'b0, ST_OK);
          if (gw_req_pos - HDR_LEN + 9'd1 >= 9'(gw_pdu_len)) begin
            expect_result(PORT_BUS, gw_req_crc[7:0], 1'b0, ST_OK);
            expect_result(PORT_BUS, gw_req_crc[15:8], 1'b1, ST_OK);
            gw_req_pos       = '0;
            gw_reply_count   = '0;
            gw_reply_crc     = CRC_INIT;
            gw_drain_pending = 1'b0;
            gw_drain_idx     = '0;
          end else begin
            gw_req_pos = gw_req_pos + 9'd1;
          end
        end
      end
      KIND_REP: begin
        // drop bytes while draining or once the buffer is full
        if (gw_drain_pending || gw_reply_count >= 9'(REPLY_DEPTH)) begin
          effective = 1'b0;
        end else begin
          gw_reply_buf[gw_reply_count[7:0]] = d;
          gw_reply_count = gw_reply_count + 9'd1;
          gw_reply_crc   = crc16_step(gw_reply_crc, d);
        end
      end
      KIND_EOR: begin
        if (gw_drain_pending) begin
          effective = 1'b0;
        end else if (gw_reply_count < 9'(MIN_REPLY) || gw_reply_crc != 16'h0000) begin
          expect_result(PORT_TCP, gw_tid[15:8], 1'b0, ST_EXC);
          expect_result(PORT_TCP, gw_tid[7:0], 1'b0, ST_EXC);
          expect_result(PORT_TCP, 8'h00, 1'b0, ST_EXC);
          expect_result(PORT_TCP, 8'h00, 1'b0, ST_EXC);
          expect_result(PORT_TCP, 8'h00, 1'b0, ST_EXC);
          expect_result(PORT_TCP, EXC_LEN, 1'b0, ST_EXC);
          expect_result(PORT_TCP, gw_unit, 1'b0, ST_EXC);
          expect_result(PORT_TCP, gw_func | EXC_FLAG, 1'b0, ST_EXC);
          expect_result(PORT_TCP, EXC_CODE, 1'b1, ST_EXC);
          gw_reply_count = '0;
          gw_reply_crc   = CRC_INIT;
        end else begin
          expect_result(PORT_TCP, gw_tid[15:8], 1'b0, ST_OK);
          expect_result(PORT_TCP, gw_tid[7:0], 1'b0, ST_OK);
          expect_result(PORT_TCP, 8'h00, 1'b0, ST_OK);
          expect_result(PORT_TCP, 8'h00, 1'b0, ST_OK);
          expect_result(PORT_TCP, plen[15:8], 1'b0, ST_OK);
          expect_result(PORT_TCP, plen[7:0], 1'b0, ST_OK);
          gw_drain_pending = 1'b1;
          gw_drain_idx     = '0;
        end
      end
      KIND_DRN: begin
        if (!gw_drain_pending) begin
          effective = 1'b0;
        end else begin
          idx  = gw_drain_idx;
          last = (16'(idx) + 16'd1 >= plen);
          expect_result(PORT_TCP, gw_reply_buf[idx[7:0]], last, ST_OK);
          if (last) begin
            gw_drain_pending = 1'b0;
            gw_drain_idx     = '0;
            gw_reply_count   = '0;
            gw_reply_crc     = CRC_INIT;
          end else begin
            gw_drain_idx = idx + 9'd1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly short idles, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one transaction, hold it until accepted, then idle for a while
  task automatic send_item(input kind_t kind, input logic [7:0] data);
    int gap;
    bit effective;
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_framer_output(kind, data, effective);
    if (effective) items_applied++;
    gap = tx_quiet ? 0 : pick_idle();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_mbap(input logic [15:0] tid, input logic [15:0] len_field);
    send_item(KIND_REQ, tid[15:8]);
    send_item(KIND_REQ, tid[7:0]);
    send_item(KIND_REQ, 8'($urandom));
    send_item(KIND_REQ, 8'($urandom));
    send_item(KIND_REQ, len_field[15:8]);
    send_item(KIND_REQ, len_field[7:0]);
  endtask

  task automatic send_request(input logic [15:0] tid, input int pdu_len, input bit use_fill,
                              input logic [7:0] fill);
    send_mbap(tid, 16'(pdu_len));
    for (int i = 0; i < pdu_len; i++) send_item(KIND_REQ, use_fill ? fill : 8'($urandom));
  endtask

  // Send a bus reply with its CRC, optionally with one flipped bit and extra bytes
  task automatic send_reply(input int payload_len, input bit corrupt, input int extra);
    logic [7:0]  frame [$];
    logic [15:0] crc;
    int          flip;
    crc = CRC_INIT;
    for (int i = 0; i < payload_len; i++) begin
      frame.push_back(8'($urandom));
      crc = crc16_step(crc, frame[i]);
    end
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    if (corrupt) begin
      flip = $urandom_range(0, frame.size() - 1);
      frame[flip] = frame[flip] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (frame[i]) send_item(KIND_REP, frame[i]);
    repeat (extra) send_item(KIND_REP, 8'($urandom));
    send_item(KIND_EOR, 8'($urandom));
  endtask

  task automatic drain_reply(input int count);
    repeat (count) send_item(KIND_DRN, 8'($urandom));
  endtask

  // Drop valid and hold off until every expected result has arrived
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    // exception with zero tid, unit and function, then a drain with nothing pending
    send_item(KIND_EOR, 8'hFF);
    send_item(KIND_DRN, 8'h00);
    wait_all_results();
  endtask

  task automatic test_request_framing();
    send_request(16'hFFFF, 2, 1'b1, 8'hFF);
    send_request(16'h0000, 3, 1'b1, 8'h00);
    wait_all_results();
  endtask

  task automatic test_bad_length();
    // nonzero high byte, too short, too long
    send_mbap(16'h1234, 16'h0105);
    send_mbap(16'hABCD, 16'd1);
    send_mbap(16'h5A5A, 16'd254);
    wait_all_results();
  endtask

  task automatic test_reply_frames();
    // shortest good frame
    send_reply(2, 1'b0, 0);
    drain_reply(2);
    // bad CRC, short frame and empty frame all give the exception
    send_reply(3, 1'b1, 0);
    send_reply(1, 1'b0, 0);
    send_item(KIND_EOR, 8'h00);
    // reply traffic during a drain is ignored
    send_reply(3, 1'b0, 0);
    send_item(KIND_REP, 8'h55);
    send_item(KIND_EOR, 8'hAA);
    drain_reply(3);
    send_item(KIND_DRN, 8'hFF);
    wait_all_results();
  endtask

  task automatic test_extremes();
    // fill the reply buffer exactly, then overflow it
    send_reply(254, 1'b0, 1);
    drain_reply(3);
    // a new request abandons the pending drain
    send_request(16'h0001, 2, 1'b0, 8'h00);
    drain_reply(1);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    // stall the result side so the command queue fills and in_ready drops
    sink_hold_cycles = 300;
    tx_quiet = 1'b1;
    send_request(16'hC3A5, 12, 1'b0, 8'h00);
    send_reply(6, 1'b0, 0);
    drain_reply(6);
    tx_quiet = 1'b0;
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    int n;
    int plen;
    target = items_applied + RANDOM_ITEMS;
    while (items_applied < target) begin
      tx_quiet = ($urandom_range(0, 7) == 0);
      rx_quiet = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 42) begin
        // finish any partial request, then send a whole one
        while (gw_req_pos != 0) send_item(KIND_REQ, 8'($urandom));
        n = $urandom_range(0, 99);
        plen = (n < 85) ? $urandom_range(2, 8) :
               (n < 98) ? $urandom_range(9, 40) : $urandom_range(41, 253);
        send_request(16'($urandom), plen, 1'b0, 8'h00);
      end else if (r < 72) begin
        if (gw_drain_pending && $urandom_range(0, 1) == 1) begin
          while (gw_drain_pending) send_item(KIND_DRN, 8'($urandom));
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        send_reply(n, $urandom_range(0, 5) == 0, 0);
        if (gw_drain_pending) begin
          // usually drain exactly, sometimes stop short or overrun
          n = int'(gw_reply_count) - 2;
          r = $urandom_range(0, 9);
          if (r == 0) n = $urandom_range(0, n - 1);
          else if (r == 1) n = n + $urandom_range(1, 2);
          drain_reply(n);
        end
      end else if (r < 80) begin
        while (gw_req_pos != 0) send_item(KIND_REQ, 8'($urandom));
        r = $urandom_range(0, 2);
        send_mbap(16'($urandom), (r == 0) ? 16'($urandom_range(256, 65535)) :
                                 (r == 1) ? 16'($urandom_range(0, 1)) :
                                            16'($urandom_range(254, 255)));
      end else if (r < 88) begin
        // leave a request unfinished for later traffic to complete
        while (gw_req_pos != 0) send_item(KIND_REQ, 8'($urandom));
        plen = $urandom_range(2, 10);
        send_mbap(16'($urandom), 16'(plen));
        repeat ($urandom_range(0, plen - 1)) send_item(KIND_REQ, 8'($urandom));
      end else if (r < 96) begin
        repeat ($urandom_range(1, 4)) send_item(kind_t'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        wait_all_results();
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_all_results();
  endtask

  // Drive out_ready: forced holds first, then always ready while rx_quiet, else random stalls
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        sink_hold_cycles--;
      end else if (rx_quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_idle();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    gw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result port %0d byte %02h last %0d status %0d",
                 $time, out_port, out_byte, out_last, out_status);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_port !== want.port) begin
          $display("%0t: port mismatch, expected %0d actual %0d", $time, want.port, out_port);
          error_count++;
        end
        if (out_byte !== want.octet) begin
          $display("%0t: byte mismatch, expected %02h actual %02h", $time, want.octet,
                   out_byte);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %0d actual %0d", $time, want.last, out_last);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status,
                   out_status);
          error_count++;
        end
      end
    end
  end

  // Abort a run that hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_request_framing();
    test_bad_length();
    test_reply_frames();
    test_extremes();
    test_backpressure();
    test_random_traffic();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
